>>> hdl/shortest_path_relaxation_engine_core_assert.svh
// assertion macros for the shortest path relaxation engine
// expects clk_i and rst_ni in the scope that uses them
`ifndef SHORTEST_PATH_RELAXATION_ENGINE_CORE_ASSERT_SVH
`define SHORTEST_PATH_RELAXATION_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SRPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SRPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/srpe_pkg.sv
// shared widths, codes and distance limits of the shortest path relaxation engine
// no dependencies
package srpe_pkg;

  localparam int CMD_W      = 2;
  localparam int NODE_IDX_W = 6;
  localparam int CFG_W      = 7;
  localparam int IN_WT_W    = 32;
  localparam int DIST_W     = 40;
  localparam int PRED_W     = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
  localparam logic signed [PRED_W-1:0] PRED_NONE = {PRED_W{1'b1}};

endpackage

>>> hdl/srpe_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module srpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hdl/shortest_path_relaxation_engine_core.sv
// single source shortest path engine: edge table load/clear and sequenced relaxation runs.
// A clear or a load is taken from S_IDLE. A run writes the start node, then in each
// relaxation round (at most node_count-1, plus one check round) scans the sources and,
// per reached source, reads its distance and walks the edge table, checking each edge and
// reading and comparing the destination of each edge that leaves that source toward a
// node in use, then closes the round; the check round stops at the first edge that still
// improves. Each result beat is then read and loaded, held while the output stalls. One
// read port per table and one shared add/saturate/compare path serve one edge at a time.
// Depends on srpe_pkg, srpe_ram and shortest_path_relaxation_engine_core_assert.svh.
//
// A load whose endpoints are at or above node_count, or that finds the table full, is
// dropped. Node count 0 behaves as 1 and values above MAX_NODES behave as MAX_NODES.
// A run from a start node outside the graph reports every node unreachable. Each run
// emits one beat per node in ascending order, last set on the final node; the negative
// cycle flag is the same on every beat of a run. Loads and clears are taken while the
// last result beat of a run still waits at the output.
module shortest_path_relaxation_engine_core #(
  parameter int MAX_NODES   = 64,
  parameter int MAX_EDGES   = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [srpe_pkg::CFG_W-1:0]             cfg_data_i,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [srpe_pkg::CMD_W-1:0]             command_i,
  input  logic [srpe_pkg::NODE_IDX_W-1:0]        edge_source_i,
  input  logic [srpe_pkg::NODE_IDX_W-1:0]        edge_dest_i,
  input  logic signed [srpe_pkg::IN_WT_W-1:0]    edge_weight_i,
  input  logic [srpe_pkg::NODE_IDX_W-1:0]        start_node_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [srpe_pkg::NODE_IDX_W-1:0]        node_index_o,
  output logic                                   reachable_o,
  output logic signed [srpe_pkg::DIST_W-1:0]     path_distance_o,
  output logic signed [srpe_pkg::PRED_W-1:0]     predecessor_o,
  output logic                                   negative_cycle_o,
  output logic                                   last_o
);

  import srpe_pkg::*;

  // node index, node count, edge address and edge count widths
  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW  = $clog2(MAX_EDGES + 1);
  // candidate sum width, one above the wider operand
  localparam int SW  = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;
  localparam int ERW = 2 * NODE_IDX_W + WEIGHT_BITS;
  localparam int NRW = DIST_W + PRED_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRC,
    S_SRC_CAP,
    S_EDGE_RD,
    S_EDGE_CHK,
    S_NODE_CMP,
    S_PASS_END,
    S_OUT_RD,
    S_OUT_LOAD
  } state_e;

  state_e                    state_q, state_d;
  logic [CFG_W-1:0]          cfg_q, cfg_d;
  logic [EW-1:0]             edges_q, edges_d;
  logic [MAX_NODES-1:0]      reach_q, reach_d;
  logic [CW-1:0]             u_q, u_d;
  logic [CW-1:0]             i_q, i_d;
  logic [CW-1:0]             round_q, round_d;
  logic [EW-1:0]             e_q, e_d;
  logic                      test_q, test_d;
  logic                      changed_q, changed_d;
  logic                      cycle_q, cycle_d;
  logic signed [DIST_W-1:0]  du_q, du_d;
  logic signed [DIST_W-1:0]  cand_q, cand_d;
  logic [NW-1:0]             v_q, v_d;

  logic                      out_valid_q, out_valid_d;
  logic [NODE_IDX_W-1:0]     out_idx_q, out_idx_d;
  logic                      out_reach_q, out_reach_d;
  logic signed [DIST_W-1:0]  out_dist_q, out_dist_d;
  logic signed [PRED_W-1:0]  out_pred_q, out_pred_d;
  logic                      out_cycle_q, out_cycle_d;
  logic                      out_last_q, out_last_d;

  // effective node count
  logic [CW-1:0]             n_eff;

  // ram ports
  logic                      edge_we, edge_re;
  logic [AW-1:0]             edge_waddr, edge_raddr;
  logic [ERW-1:0]            edge_wdata, edge_rdata;
  logic                      node_we, node_re;
  logic [NW-1:0]             node_waddr, node_raddr;
  logic [NRW-1:0]            node_wdata, node_rdata;

  // unpacked edge and node read data
  logic [NODE_IDX_W-1:0]     rd_src, rd_dst;
  logic [WEIGHT_BITS-1:0]    rd_wt;
  logic signed [DIST_W-1:0]  rd_dist;
  logic signed [PRED_W-1:0]  rd_pred;

  // weight as stored, and the saturating candidate path
  logic [WEIGHT_BITS+IN_WT_W-1:0] wt_wide;
  logic signed [SW-1:0]      cand_sum;
  logic signed [DIST_W-1:0]  cand_sat;

  logic in_acc, out_acc, cfg_acc;
  logic edge_hit, relax;
  logic edge_done;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign node_index_o     = out_idx_q;
  assign reachable_o      = out_reach_q;
  assign path_distance_o  = out_dist_q;
  assign predecessor_o    = out_pred_q;
  assign negative_cycle_o = out_cycle_q;
  assign last_o           = out_last_q;

  always_comb begin
    if (cfg_q == '0) begin
      n_eff = CW'(1);
    end else if (cfg_q > CFG_W'(MAX_NODES)) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = cfg_q[CW-1:0];
    end
  end

  // weight is reinterpreted as a WEIGHT_BITS two's complement value
  assign wt_wide    = {{WEIGHT_BITS{1'b0}}, edge_weight_i};
  assign edge_wdata = {edge_source_i, edge_dest_i, wt_wide[WEIGHT_BITS-1:0]};
  assign edge_waddr = edges_q[AW-1:0];
  assign edge_raddr = e_q[AW-1:0];

  assign rd_src  = edge_rdata[ERW-1 -: NODE_IDX_W];
  assign rd_dst  = edge_rdata[WEIGHT_BITS +: NODE_IDX_W];
  assign rd_wt   = edge_rdata[WEIGHT_BITS-1:0];
  assign rd_dist = node_rdata[NRW-1 -: DIST_W];
  assign rd_pred = node_rdata[PRED_W-1:0];

  // candidate distance, saturated to the distance range
  assign cand_sum = SW'(du_q) + SW'($signed(rd_wt));
  always_comb begin
    if (cand_sum > SW'(DIST_MAX)) begin
      cand_sat = DIST_MAX;
    end else if (cand_sum < SW'(DIST_MIN)) begin
      cand_sat = DIST_MIN;
    end else begin
      cand_sat = cand_sum[DIST_W-1:0];
    end
  end

  assign edge_hit  = (rd_src == NODE_IDX_W'(u_q)) && (CW'(rd_dst) < n_eff);
  assign relax     = !reach_q[v_q] || (cand_q < rd_dist);
  assign edge_done = ((e_q + EW'(1)) == edges_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    cfg_d       = cfg_q;
    edges_d     = edges_q;
    reach_d     = reach_q;
    u_d         = u_q;
    i_d         = i_q;
    round_d     = round_q;
    e_d         = e_q;
    test_d      = test_q;
    changed_d   = changed_q;
    cycle_d     = cycle_q;
    du_d        = du_q;
    cand_d      = cand_q;
    v_d         = v_q;
    out_valid_d = out_valid_q && !out_acc;
    out_idx_d   = out_idx_q;
    out_reach_d = out_reach_q;
    out_dist_d  = out_dist_q;
    out_pred_d  = out_pred_q;
    out_cycle_d = out_cycle_q;
    out_last_d  = out_last_q;

    edge_we    = 1'b0;
    edge_re    = 1'b0;
    node_we    = 1'b0;
    node_re    = 1'b0;
    node_waddr = v_q;
    node_wdata = {cand_q, PRED_W'({1'b0, u_q})};
    node_raddr = u_q[NW-1:0];

    if (cfg_acc) begin
      cfg_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (command_i)
            CMD_CLEAR: begin
              edges_d = '0;
            end
            CMD_LOAD: begin
              if (edges_q < EW'(MAX_EDGES) && CW'(edge_source_i) < n_eff &&
                  CW'(edge_dest_i) < n_eff) begin
                edge_we = 1'b1;
                edges_d = edges_q + EW'(1);
              end
            end
            CMD_RUN: begin
              reach_d   = '0;
              cycle_d   = 1'b0;
              u_d       = '0;
              i_d       = '0;
              round_d   = '0;
              changed_d = 1'b0;
              if (CW'(start_node_i) < n_eff) begin
                // start node: distance zero, no parent
                reach_d[start_node_i[NW-1:0]] = 1'b1;
                node_we    = 1'b1;
                node_waddr = start_node_i[NW-1:0];
                node_wdata = {{DIST_W{1'b0}}, PRED_NONE};
                // a single node graph goes straight to the check round
                test_d     = (n_eff == CW'(1));
                state_d    = S_SRC;
              end else begin
                state_d = S_OUT_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SRC: begin
        if (u_q == n_eff) begin
          state_d = S_PASS_END;
        end else if (reach_q[u_q[NW-1:0]]) begin
          node_re = 1'b1;
          state_d = S_SRC_CAP;
        end else begin
          u_d = u_q + CW'(1);
        end
      end

      S_SRC_CAP: begin
        du_d = rd_dist;
        e_d  = '0;
        if (edges_q == '0) begin
          u_d     = u_q + CW'(1);
          state_d = S_SRC;
        end else begin
          state_d = S_EDGE_RD;
        end
      end

      S_EDGE_RD: begin
        edge_re = 1'b1;
        state_d = S_EDGE_CHK;
      end

      S_EDGE_CHK: begin
        if (edge_hit) begin
          node_re    = 1'b1;
          node_raddr = rd_dst[NW-1:0];
          v_d        = rd_dst[NW-1:0];
          cand_d     = cand_sat;
          state_d    = S_NODE_CMP;
        end else if (edge_done) begin
          u_d     = u_q + CW'(1);
          state_d = S_SRC;
        end else begin
          e_d     = e_q + EW'(1);
          state_d = S_EDGE_RD;
        end
      end

      S_NODE_CMP: begin
        if (relax && test_q) begin
          // check round found a further improvement
          cycle_d = 1'b1;
          i_d     = '0;
          state_d = S_OUT_RD;
        end else begin
          if (relax) begin
            node_we    = 1'b1;
            reach_d[v_q] = 1'b1;
            changed_d  = 1'b1;
            // a self loop moves the source's own distance
            if (CW'(v_q) == u_q) begin
              du_d = cand_q;
            end
          end
          if (edge_done) begin
            u_d     = u_q + CW'(1);
            state_d = S_SRC;
          end else begin
            e_d     = e_q + EW'(1);
            state_d = S_EDGE_RD;
          end
        end
      end

      S_PASS_END: begin
        u_d       = '0;
        changed_d = 1'b0;
        if (test_q) begin
          i_d     = '0;
          state_d = S_OUT_RD;
        end else begin
          if (!changed_q ||
              !((CW+1)'(round_q) + (CW+1)'(2) < (CW+1)'(n_eff))) begin
            test_d = 1'b1;
          end else begin
            round_d = round_q + CW'(1);
          end
          state_d = S_SRC;
        end
      end

      S_OUT_RD: begin
        node_re    = 1'b1;
        node_raddr = i_q[NW-1:0];
        state_d    = S_OUT_LOAD;
      end

      S_OUT_LOAD: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_idx_d   = NODE_IDX_W'(i_q);
          out_reach_d = reach_q[i_q[NW-1:0]];
          out_dist_d  = reach_q[i_q[NW-1:0]] ? rd_dist : '0;
          out_pred_d  = reach_q[i_q[NW-1:0]] ? rd_pred : PRED_NONE;
          out_cycle_d = cycle_q;
          out_last_d  = ((CW+1)'(i_q) + (CW+1)'(1)) == (CW+1)'(n_eff);
          if (((CW+1)'(i_q) + (CW+1)'(1)) == (CW+1)'(n_eff)) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = S_OUT_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= NODE_COUNT_RESET;
      edges_q     <= '0;
      reach_q     <= '0;
      u_q         <= '0;
      i_q         <= '0;
      round_q     <= '0;
      e_q         <= '0;
      test_q      <= 1'b0;
      changed_q   <= 1'b0;
      cycle_q     <= 1'b0;
      du_q        <= '0;
      cand_q      <= '0;
      v_q         <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_reach_q <= 1'b0;
      out_dist_q  <= '0;
      out_pred_q  <= '0;
      out_cycle_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      edges_q     <= edges_d;
      reach_q     <= reach_d;
      u_q         <= u_d;
      i_q         <= i_d;
      round_q     <= round_d;
      e_q         <= e_d;
      test_q      <= test_d;
      changed_q   <= changed_d;
      cycle_q     <= cycle_d;
      du_q        <= du_d;
      cand_q      <= cand_d;
      v_q         <= v_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      out_reach_q <= out_reach_d;
      out_dist_q  <= out_dist_d;
      out_pred_q  <= out_pred_d;
      out_cycle_q <= out_cycle_d;
      out_last_q  <= out_last_d;
    end
  end

  // edge table: source, destination, weight
  srpe_ram #(
    .WIDTH (ERW),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  // node table: distance and parent
  srpe_ram #(
    .WIDTH (NRW),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  // checks
  `include "shortest_path_relaxation_engine_core_assert.svh"

  `SRPE_ASSERT_NOW(a_edges_cap, 1'b1, edges_q <= EW'(MAX_EDGES), "edge count past capacity")
  `SRPE_ASSERT_NEXT(a_node_wr_reach, node_we, reach_q[$past(node_waddr)], "written node not reached")
  `SRPE_ASSERT_NOW(a_cycle_in_check, $rose(cycle_q), $past(test_q), "cycle flag outside check round")

endmodule

>>> test/tb.sv
// self-checking testbench for shortest_path_relaxation_engine_core: a directed opening table
// and random graph phases checked against an in-bench path solver
// depends on srpe_pkg and the engine core rtl only
module tb;
  import srpe_pkg::*;

  localparam int MAX_N        = 64;
  localparam int EDGE_CAP     = 1024;
  localparam int RANDOM_ITEMS = 140;
  localparam int SETTLE       = 8;     // settling margin before a node count write
  localparam int TAIL_CYCLES  = 40;
  localparam int N_ROWS       = 26;

  localparam longint DIST_CEIL  = longint'(DIST_MAX);
  localparam longint DIST_FLOOR = longint'(DIST_MIN);

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_NONE,      // clear, load or unknown command, no result
    CHK_PREDICT,   // results from the path solver
    CHK_ISOLATED,  // only the start node reachable, all else blank
    CHK_NOWHERE    // start outside the graph, every node unreachable
  } check_e;

  typedef struct packed {
    logic [6:0]  node_code;  // node_count held for this row
    cmd_e        cmd;
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [31:0] wt;
    logic [5:0]  start_at;
    check_e      chk;
  } stim_row_t;

  typedef struct packed {
    logic [5:0]  node;
    logic        reach;
    logic [39:0] distance;
    logic [6:0]  pred;
    logic        neg_cycle;
    logic        is_last;
  } node_report_t;

  // dut signals
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [CMD_W-1:0] command_i = '0;
  logic [NODE_IDX_W-1:0] edge_source_i = '0;
  logic [NODE_IDX_W-1:0] edge_dest_i = '0;
  logic signed [IN_WT_W-1:0] edge_weight_i = '0;
  logic [NODE_IDX_W-1:0] start_node_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [NODE_IDX_W-1:0] node_index_o;
  logic reachable_o;
  logic signed [DIST_W-1:0] path_distance_o;
  logic signed [PRED_W-1:0] predecessor_o;
  logic negative_cycle_o;
  logic last_o;

  // mirror of the engine state
  logic [5:0] edge_from [EDGE_CAP];
  logic [5:0] edge_to [EDGE_CAP];
  longint edge_cost [EDGE_CAP];
  int edge_total = 0;
  logic [6:0] node_reg = NODE_COUNT_RESET;
  longint best_dist [MAX_N];
  bit reached [MAX_N];
  int via [MAX_N];

  node_report_t awaited_nodes [$];

  // bookkeeping
  bit idling_on = 1'b1;
  int stall_left = 0;
  int faults = 0;
  int beats_seen = 0;
  int effective_beats = 0;
  int path_runs = 0;
  int cfg_writes = 0;

  // directed opening: extremes, every command and the special cases
  stim_row_t opening_rows [N_ROWS] = '{
    // fresh after reset, empty edge table
    '{7'd64,  CMD_RUN,  6'd0,  6'd0,  32'h0000_0000, 6'd0,  CHK_ISOLATED},
    '{7'd64,  CMD_RUN,  6'd0,  6'd0,  32'h0000_0000, 6'd63, CHK_ISOLATED},
    // unknown command with every field high
    '{7'd64,  CMD_NONE, 6'd63, 6'd63, 32'hffff_ffff, 6'd63, CHK_NONE},
    // ring 0-1-2-63-0 with extreme weights, total -2
    '{7'd64,  CMD_LOAD, 6'd0,  6'd1,  32'h7fff_ffff, 6'd0,  CHK_NONE},
    '{7'd64,  CMD_LOAD, 6'd1,  6'd2,  32'h8000_0000, 6'd0,  CHK_NONE},
    '{7'd64,  CMD_LOAD, 6'd2,  6'd63, 32'h0000_0000, 6'd0,  CHK_NONE},
    '{7'd64,  CMD_LOAD, 6'd63, 6'd0,  32'hffff_ffff, 6'd0,  CHK_NONE},
    '{7'd64,  CMD_RUN,  6'd0,  6'd0,  32'h0000_0000, 6'd0,  CHK_PREDICT},
    // node 5 has no outgoing edges
    '{7'd64,  CMD_RUN,  6'd0,  6'd0,  32'h0000_0000, 6'd5,  CHK_ISOLATED},
    // alternating bit patterns, pair sums to -1
    '{7'd64,  CMD_LOAD, 6'd42, 6'd21, 32'h5555_5555, 6'd0,  CHK_NONE},
    '{7'd64,  CMD_LOAD, 6'd21, 6'd42, 32'haaaa_aaaa, 6'd0,  CHK_NONE},
    '{7'd64,  CMD_RUN,  6'd0,  6'd0,  32'h0000_0000, 6'd21, CHK_PREDICT},
    '{7'd64,  CMD_CLEAR, 6'd0, 6'd0,  32'h0000_0000, 6'd0,  CHK_NONE},
    '{7'd64,  CMD_RUN,  6'd0,  6'd0,  32'h0000_0000, 6'd1,  CHK_ISOLATED},
    // negative self loop plus a short-cut that loses
    '{7'd64,  CMD_LOAD, 6'd3,  6'd3,  32'hffff_fffb, 6'd0,  CHK_NONE},
    '{7'd64,  CMD_LOAD, 6'd3,  6'd4,  32'h0000_0007, 6'd0,  CHK_NONE},
    '{7'd64,  CMD_LOAD, 6'd4,  6'd5,  32'h0000_0002, 6'd0,  CHK_NONE},
    '{7'd64,  CMD_LOAD, 6'd3,  6'd5,  32'h0000_0014, 6'd0,  CHK_NONE},
    '{7'd64,  CMD_RUN,  6'd0,  6'd0,  32'h0000_0000, 6'd3,  CHK_PREDICT},
    // small graph: out-of-range endpoints dropped, out-of-range start
    '{7'd8,   CMD_LOAD, 6'd9,  6'd2,  32'h0000_0001, 6'd0,  CHK_NONE},
    '{7'd8,   CMD_LOAD, 6'd2,  6'd60, 32'h0000_0001, 6'd0,  CHK_NONE},
    '{7'd8,   CMD_LOAD, 6'd5,  6'd3,  32'hffff_ffe2, 6'd0,  CHK_NONE},
    '{7'd8,   CMD_RUN,  6'd0,  6'd0,  32'h0000_0000, 6'd9,  CHK_NOWHERE},
    '{7'd8,   CMD_RUN,  6'd0,  6'd0,  32'h0000_0000, 6'd4,  CHK_PREDICT},
    // node count 0 acts as 1, above 64 acts as 64
    '{7'd0,   CMD_RUN,  6'd0,  6'd0,  32'h0000_0000, 6'd0,  CHK_PREDICT},
    '{7'd127, CMD_RUN,  6'd0,  6'd0,  32'h0000_0000, 6'd63, CHK_PREDICT}
  };

  shortest_path_relaxation_engine_core #(
    .MAX_NODES   (MAX_N),
    .MAX_EDGES   (EDGE_CAP),
    .WEIGHT_BITS (32)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .edge_source_i    (edge_source_i),
    .edge_dest_i      (edge_dest_i),
    .edge_weight_i    (edge_weight_i),
    .start_node_i     (start_node_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .node_index_o     (node_index_o),
    .reachable_o      (reachable_o),
    .path_distance_o  (path_distance_o),
    .predecessor_o    (predecessor_o),
    .negative_cycle_o (negative_cycle_o),
    .last_o           (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // path solver
  // ---------------------------------------------------------------------------

  // effective node count: 0 behaves as 1, above the maximum clips
  function automatic int nodes_active();
    if (node_reg == 0) return 1;
    if (node_reg > MAX_N) return MAX_N;
    return int'(node_reg);
  endfunction

  // one sweep over reached sources in ascending order, edges in load order;
  // with apply clear it only probes for a further improvement
  function automatic bit relax_round(int n, bit apply);
    bit moved;
    longint cand;
    int v;
    moved = 1'b0;
    for (int u = 0; u < n; u++) begin
      if (!reached[u]) continue;
      for (int e = 0; e < edge_total; e++) begin
        if (edge_from[e] != u) continue;
        v = int'(edge_to[e]);
        // stored edge may point past a node count lowered since the load
        if (v >= n) continue;
        cand = best_dist[u] + edge_cost[e];
        if (cand > DIST_CEIL) cand = DIST_CEIL;
        if (cand < DIST_FLOOR) cand = DIST_FLOOR;
        // saturated candidate must be strictly better
        if (!reached[v] || cand < best_dist[v]) begin
          if (!apply) return 1'b1;
          best_dist[v] = cand;
          reached[v] = 1'b1;
          via[v] = u;
          moved = 1'b1;
        end
      end
    end
    return moved;
  endfunction

  // queue one report per node in use
  function automatic void post_reports(int n, bit neg_cycle);
    node_report_t r;
    for (int i = 0; i < n; i++) begin
      r.node = 6'(i);
      r.reach = reached[i];
      r.distance = reached[i] ? 40'(best_dist[i]) : '0;
      r.pred = reached[i] ? 7'(via[i]) : PRED_NONE;
      r.neg_cycle = neg_cycle;
      r.is_last = (i == n - 1);
      awaited_nodes.insert(awaited_nodes.size(), r);
    end
  endfunction

  function automatic void clear_scratch();
    for (int i = 0; i < MAX_N; i++) begin
      best_dist[i] = 0;
      reached[i] = 1'b0;
      via[i] = -1;
    end
  endfunction

  // full run: up to n-1 rounds with early stop, then the cycle probe
  function automatic void solve_paths(logic [5:0] start_at, int n);
    bit neg_cycle;
    clear_scratch();
    neg_cycle = 1'b0;
    if (start_at < n) begin
      reached[start_at] = 1'b1;
      for (int r = 0; r + 1 < n; r++)
        if (!relax_round(n, 1'b1)) break;
      neg_cycle = relax_round(n, 1'b0);
    end
    post_reports(n, neg_cycle);
  endfunction

  // hand-written outcome: start alone (or nothing) reachable, no cycle
  function automatic void post_plain_run(logic [5:0] start_at, int n, bit start_counts);
    clear_scratch();
    if (start_counts) reached[start_at] = 1'b1;
    post_reports(n, 1'b0);
  endfunction

  // update the mirror for one accepted beat; returns 0 if the engine ignores it
  function automatic bit take_item(cmd_e cmd, logic [5:0] src, logic [5:0] dst,
                                   logic [31:0] wt, logic [5:0] start_at, check_e chk);
    int n;
    n = nodes_active();
    case (cmd)
      CMD_CLEAR: begin
        edge_total = 0;
        return 1'b1;
      end
      CMD_LOAD: begin
        // full table or endpoint outside the graph: dropped
        if (edge_total >= EDGE_CAP || src >= n || dst >= n) return 1'b0;
        edge_from[edge_total] = src;
        edge_to[edge_total] = dst;
        edge_cost[edge_total] = longint'($signed(wt));
        edge_total++;
        return 1'b1;
      end
      CMD_RUN: begin
        path_runs++;
        case (chk)
          CHK_ISOLATED: post_plain_run(start_at, n, 1'b1);
          CHK_NOWHERE:  post_plain_run(start_at, n, 1'b0);
          default:      solve_paths(start_at, n);
        endcase
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers, all changes at the falling edge
  // ---------------------------------------------------------------------------

  task automatic push_item(cmd_e cmd, logic [5:0] src, logic [5:0] dst, logic [31:0] wt,
                           logic [5:0] start_at, check_e chk);
    // random sender gap before the beat
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    command_i = cmd;
    edge_source_i = src;
    edge_dest_i = dst;
    edge_weight_i = wt;
    start_node_i = start_at;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (take_item(cmd, src, dst, wt, start_at, chk)) effective_beats++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    while (awaited_nodes.size() != 0) @(negedge clk_i);
  endtask

  // register write only with the engine idle
  task automatic set_node_count(logic [6:0] code);
    in_valid_i = 1'b0;
    wait_for_results();
    repeat (SETTLE) @(negedge clk_i);
    cfg_data_i = code;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    node_reg = code;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom();
      default: return 32'($urandom_range(0, 40)) - 32'd12;
    endcase
  endfunction

  // receiver stall bursts, started only while idling is on
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i = 1'b1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // result checking at the rising edge
  // ---------------------------------------------------------------------------

  function automatic void note_fault(string msg);
    faults++;
    if (faults <= 10) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  function automatic void cmp_field(string name, logic [5:0] node, logic [63:0] want,
                                    logic [63:0] got);
    if (got !== want)
      note_fault($sformatf("node %0d %s: expected %h actual %h", node, name, want, got));
  endfunction

  always @(posedge clk_i) begin
    node_report_t want;
    node_report_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen++;
      got = '{node_index_o, reachable_o, path_distance_o, predecessor_o,
              negative_cycle_o, last_o};
      if (awaited_nodes.size() == 0) begin
        note_fault($sformatf("result beat for node %0d with nothing awaited", node_index_o));
      end else begin
        want = awaited_nodes.pop_front();
        cmp_field("node_index", want.node, 64'(want.node), 64'(got.node));
        cmp_field("reachable", want.node, 64'(want.reach), 64'(got.reach));
        cmp_field("path_distance", want.node, 64'(want.distance), 64'(got.distance));
        cmp_field("predecessor", want.node, 64'(want.pred), 64'(got.pred));
        cmp_field("negative_cycle", want.node, 64'(want.neg_cycle), 64'(got.neg_cycle));
        cmp_field("last", want.node, 64'(want.is_last), 64'(got.is_last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int base;
    int n;
    int n_loads;
    bit wide;
    logic [6:0] code;
    logic [5:0] src;
    logic [5:0] dst;
    logic [5:0] start_at;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed opening
    foreach (opening_rows[k]) begin
      if (opening_rows[k].node_code != node_reg) set_node_count(opening_rows[k].node_code);
      push_item(opening_rows[k].cmd, opening_rows[k].src, opening_rows[k].dst,
                opening_rows[k].wt, opening_rows[k].start_at, opening_rows[k].chk);
    end

    // random graph phases, each under a fresh node count
    base = effective_beats;
    while (effective_beats - base < RANDOM_ITEMS) begin
      // last fifth of the run without idling on either side
      idling_on = (effective_beats - base < RANDOM_ITEMS * 4 / 5) && ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 9))
        0:       code = 7'd0;
        1:       code = 7'd127;
        2:       code = 7'd64;
        3:       code = 7'($urandom_range(1, 127));
        default: code = 7'($urandom_range(2, 12));
      endcase
      set_node_count(code);
      n = nodes_active();
      // keep runs on big graphs short
      wide = (n > 16);
      if (wide || edge_total > 40 || $urandom_range(0, 1) == 1)
        push_item(CMD_CLEAR, 6'($urandom()), 6'($urandom()), $urandom(), 6'($urandom()),
                  CHK_NONE);
      n_loads = wide ? $urandom_range(1, 12) : $urandom_range(2, 16);
      repeat (n_loads) begin
        if ($urandom_range(0, 9) == 0) begin
          src = 6'($urandom_range(0, 63));
          dst = 6'($urandom_range(0, 63));
        end else begin
          src = 6'($urandom_range(0, n - 1));
          dst = 6'($urandom_range(0, n - 1));
        end
        push_item(CMD_LOAD, src, dst, pick_weight(), 6'($urandom()), CHK_NONE);
        if ($urandom_range(0, 19) == 0)
          push_item(CMD_NONE, 6'($urandom()), 6'($urandom()), $urandom(), 6'($urandom()),
                    CHK_NONE);
      end
      repeat ($urandom_range(1, 2)) begin
        start_at = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, n - 1));
        push_item(CMD_RUN, 6'($urandom()), 6'($urandom()), $urandom(), start_at, CHK_PREDICT);
      end
      // sender sometimes holds off until every report is back
      if ($urandom_range(0, 3) == 0) begin
        in_valid_i = 1'b0;
        wait_for_results();
      end
    end

    in_valid_i = 1'b0;
    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("covered %0d effective input beats, %0d path runs, %0d node count writes",
             effective_beats, path_runs, cfg_writes);
    $display("%0d result beats compared, %0d faults", beats_seen, faults);
    if (faults == 0 && awaited_nodes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400_000_000;
    $display("timeout with %0d reports still awaited", awaited_nodes.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
